// File: design/banded_dtw_cost_accumulator_macros.svh
// Assertion helpers; each expects signals named clock and reset in scope.
`ifndef BANDED_DTW_COST_ACCUMULATOR_MACROS_SVH
`define BANDED_DTW_COST_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define BDTW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BDTW_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bdtw_pkg.sv
package bdtw_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int ADDR_W      = $clog2(MAX_COLS);
   localparam int COL_W       = 10;
   localparam int SPAN_W      = 11;
   localparam int DIST_W      = 8;
   localparam int START_W     = 31;
   localparam int COST_W      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COST_W-1:0] COST_MAX  = {1'b0, {(COST_W-1){1'b1}}};
   localparam logic [COST_W-1:0] COST_NONE = {COST_W{1'b1}};

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_VERT  = 2'd1,
      DIR_HORIZ = 2'd2,
      DIR_DIAG  = 2'd3
   } bdtw_dir_type;

   typedef struct packed {
      logic [DIST_W-1:0]  local_distance;
      logic [COL_W-1:0]   column;
      logic [START_W-1:0] start_cost;
      logic               new_region;
      logic               diag_ok;
      logic               vert_ok;
      logic               horiz_ok;
      logic               diag_mem;
   } bdtw_cell_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } bdtw_qstat_type;

   function automatic logic [ADDR_W-1:0] col_addr(input logic [COL_W-1:0] col);
      return ADDR_W'(col);
   endfunction

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] pred,
                                                 input logic [DIST_W:0]   add);
      logic [COST_W:0] sum;
      sum = {pred[COST_W-1], pred} + {{(COST_W-DIST_W){1'b0}}, add};
      if (!sum[COST_W] && sum[COST_W-1]) begin
         return COST_MAX;
      end
      return sum[COST_W-1:0];
   endfunction

endpackage

// File: design/bdtw_req_if.sv
interface bdtw_req_if import bdtw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DIST_W-1:0]  local_distance;
   logic [COL_W-1:0]   column;
   logic               new_row;
   logic               new_region;
   logic [START_W-1:0] start_cost;

   modport source (output valid, local_distance, column, new_row, new_region, start_cost,
                   input ready);
   modport sink   (input valid, local_distance, column, new_row, new_region, start_cost,
                   output ready);
endinterface

// File: design/bdtw_rsp_if.sv
interface bdtw_rsp_if import bdtw_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COST_W-1:0] path_cost;
   logic [1:0]               step_dir;

   modport source (output valid, path_cost, step_dir, input ready);
   modport sink   (input valid, path_cost, step_dir, output ready);
endinterface

// File: design/bdtw_ram.sv
module bdtw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: design/bdtw_front.sv
module bdtw_front import bdtw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   bdtw_req_if.sink       req_chan,
   input  bdtw_qstat_type qstat,
   output logic           push,
   output bdtw_cell_type  push_cell
);

   logic [SPAN_W-1:0] prev_start_ff, prev_start_in;
   logic [SPAN_W-1:0] prev_stop_ff,  prev_stop_in;
   logic [COL_W-1:0]  row_start_ff,  row_start_in;
   logic [COL_W-1:0]  last_col_ff,   last_col_in;
   logic              first_row_ff,  first_row_in;
   logic [SPAN_W-1:0] col_ext;

   assign req_chan.ready = !qstat.full;
   assign push           = req_chan.valid && !qstat.full;
   assign col_ext        = {1'b0, req_chan.column};

   always_comb begin
      prev_start_in = prev_start_ff;
      prev_stop_in  = prev_stop_ff;
      row_start_in  = row_start_ff;
      first_row_in  = first_row_ff;
      last_col_in   = req_chan.column;
      if (req_chan.new_region) begin
         prev_start_in = '0;
         prev_stop_in  = '0;
         row_start_in  = req_chan.column;
         first_row_in  = 1'b1;
      end else if (req_chan.new_row) begin
         prev_start_in = {1'b0, row_start_ff};
         prev_stop_in  = {1'b0, last_col_ff} + SPAN_W'(1);
         row_start_in  = req_chan.column;
         first_row_in  = 1'b0;
      end

      push_cell.local_distance = req_chan.local_distance;
      push_cell.column         = req_chan.column;
      push_cell.start_cost     = req_chan.start_cost;
      push_cell.new_region     = req_chan.new_region;
      push_cell.diag_mem       = req_chan.new_row && !req_chan.new_region &&
                                 (req_chan.column != '0);
      push_cell.diag_ok        = 1'b0;
      push_cell.vert_ok        = 1'b0;
      push_cell.horiz_ok       = 1'b0;
      if (!req_chan.new_region) begin
         push_cell.horiz_ok = req_chan.column > row_start_in;
         if (!first_row_in) begin
            push_cell.diag_ok = (col_ext > prev_start_in) && (col_ext <= prev_stop_in);
            push_cell.vert_ok = (col_ext >= prev_start_in) && (col_ext < prev_stop_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_start_ff <= '0;
         prev_stop_ff  <= '0;
         row_start_ff  <= '0;
         last_col_ff   <= '0;
         first_row_ff  <= 1'b1;
      end else if (push) begin
         prev_start_ff <= prev_start_in;
         prev_stop_ff  <= prev_stop_in;
         row_start_ff  <= row_start_in;
         last_col_ff   <= last_col_in;
         first_row_ff  <= first_row_in;
      end
   end

endmodule

// File: design/bdtw_queue.sv
`include "banded_dtw_cost_accumulator_macros.svh"

module bdtw_queue import bdtw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  bdtw_cell_type  push_cell,
   input  logic           pop,
   output bdtw_qstat_type qstat,
   output bdtw_cell_type  head
);

   bdtw_cell_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   assign qstat.full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign qstat.head_valid = count_ff != '0;
   assign head             = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cell;
      end
   end

   `BDTW_ASSERT_IMP(a_no_overflow, push, !qstat.full, "request pushed into full queue")
   `BDTW_ASSERT_IMP(a_no_underflow, pop, count_ff != '0, "pop from empty queue")
   `BDTW_ASSERT_NXT(a_count_up, push && !pop, count_ff == $past(count_ff) + QCNT_W'(1), "count lost a push")

endmodule

// File: design/bdtw_back.sv
`include "banded_dtw_cost_accumulator_macros.svh"

module bdtw_back import bdtw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  bdtw_qstat_type      qstat,
   input  bdtw_cell_type       head,
   output logic                pop,
   output logic                ram_wr_en,
   output logic [ADDR_W-1:0]   ram_wr_addr,
   output logic [COST_W-1:0]   ram_wr_data,
   output logic                ram_rd_en,
   output logic [ADDR_W-1:0]   ram_rd_addr_a,
   output logic [ADDR_W-1:0]   ram_rd_addr_b,
   input  logic [COST_W-1:0]   ram_rd_data_a,
   input  logic [COST_W-1:0]   ram_rd_data_b,
   bdtw_rsp_if.source          rsp_chan
);

   logic          e_valid_ff, e_valid_in;
   bdtw_cell_type e_cell_ff;
   logic          hit_a_ff,   hit_a_in;
   logic          hit_b_ff,   hit_b_in;
   logic [COST_W-1:0] fwd_ff;
   logic [COST_W-1:0] left_ff, diag_hold_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0] rsp_cost_ff;
   bdtw_dir_type  rsp_dir_ff;

   logic          e_fire;
   logic [COST_W-1:0] old_cost, mem_diag, diag_cost;
   logic [COST_W-1:0] cand_d, cand_v, cand_h;
   logic [COST_W-1:0] cost;
   bdtw_dir_type  dir;
   logic          have;

   assign e_fire = e_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign pop    = qstat.head_valid && (!e_valid_ff || e_fire);

   assign ram_rd_en     = pop;
   assign ram_rd_addr_a = col_addr(head.column);
   assign ram_rd_addr_b = col_addr(head.column - COL_W'(1));
   assign ram_wr_en     = e_fire;
   assign ram_wr_addr   = col_addr(e_cell_ff.column);
   assign ram_wr_data   = cost;

   assign hit_a_in = e_fire && (ram_wr_addr == ram_rd_addr_a);
   assign hit_b_in = e_fire && (ram_wr_addr == ram_rd_addr_b);

   assign old_cost  = hit_a_ff ? fwd_ff : ram_rd_data_a;
   assign mem_diag  = hit_b_ff ? fwd_ff : ram_rd_data_b;
   assign diag_cost = e_cell_ff.diag_mem ? mem_diag : diag_hold_ff;

   assign cand_d = sat_add(diag_cost, {e_cell_ff.local_distance, 1'b0});
   assign cand_v = sat_add(old_cost, {1'b0, e_cell_ff.local_distance});
   assign cand_h = sat_add(left_ff, {1'b0, e_cell_ff.local_distance});

   always_comb begin
      cost = COST_NONE;
      dir  = DIR_NONE;
      have = 1'b0;
      if (e_cell_ff.new_region) begin
         cost = {1'b0, e_cell_ff.start_cost};
      end else begin
         if (e_cell_ff.diag_ok) begin
            cost = cand_d;
            dir  = DIR_DIAG;
            have = 1'b1;
         end
         if (e_cell_ff.vert_ok && (!have || ($signed(cand_v) < $signed(cost)))) begin
            cost = cand_v;
            dir  = DIR_VERT;
            have = 1'b1;
         end
         if (e_cell_ff.horiz_ok && (!have || ($signed(cand_h) < $signed(cost)))) begin
            cost = cand_h;
            dir  = DIR_HORIZ;
         end
      end
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      if (pop) begin
         e_valid_in = 1'b1;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (e_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         hit_a_ff     <= 1'b0;
         hit_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
         diag_hold_ff <= '0;
      end else begin
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            hit_a_ff <= hit_a_in;
            hit_b_ff <= hit_b_in;
         end
         if (e_fire) begin
            left_ff      <= cost;
            diag_hold_ff <= old_cost;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         e_cell_ff <= head;
         fwd_ff    <= cost;
      end
      if (e_fire) begin
         rsp_cost_ff <= cost;
         rsp_dir_ff  <= dir;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.path_cost = rsp_cost_ff;
   assign rsp_chan.step_dir  = rsp_dir_ff;

   `BDTW_ASSERT_NXT(a_fire_lands, e_fire, rsp_valid_ff, "finished cell did not reach output")
   `BDTW_ASSERT_NXT(a_stall_holds, e_valid_ff && !e_fire, e_valid_ff, "stalled cell dropped")
   `BDTW_ASSERT_NXT(a_pop_lands, pop, e_valid_ff, "popped cell missing from execute stage")

endmodule

// File: design/banded_dtw_cost_accumulator.sv
// Banded DTW cost accumulator.
// req_chan carries one cost-matrix cell per request, in row-major order:
// local distance, column, new-row and new-region marks, region start cost.
// rsp_chan returns one result per request, in order: the accumulated path
// cost (-1 when the cell has no predecessor) and the step direction.
// A request passes through the queue, the execute stage and the output
// register before its result is offered. Throughput: one request per cycle,
// sustained while rsp_chan is ready. The front end tracks row and region
// spans and classifies each cell; a four-entry queue feeds the back end,
// which reads the previous row's costs from a 1024 x 32 line RAM as the
// cell is popped and does one add-and-compare chain per cell.
// Reset (synchronous, active high) clears row tracking and the left and
// diagonal holding registers; the line RAM is not cleared and needs no sweep.
// When rsp_chan stalls, the output register holds its result, the execute
// stage holds behind it, and the queue absorbs up to four more requests
// before req_chan.ready drops.
module banded_dtw_cost_accumulator import bdtw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bdtw_req_if.sink   req_chan,
   bdtw_rsp_if.source rsp_chan
);

   bdtw_qstat_type    qstat;
   bdtw_cell_type     push_cell;
   bdtw_cell_type     head;
   logic              push;
   logic              pop;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [COST_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr_a;
   logic [ADDR_W-1:0] ram_rd_addr_b;
   logic [COST_W-1:0] ram_rd_data_a;
   logic [COST_W-1:0] ram_rd_data_b;

   bdtw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .qstat     (qstat),
      .push      (push),
      .push_cell (push_cell)
   );

   bdtw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cell (push_cell),
      .pop       (pop),
      .qstat     (qstat),
      .head      (head)
   );

   bdtw_ram #(
      .WIDTH (COST_W),
      .DEPTH (MAX_COLS)
   ) u_row_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   bdtw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (qstat),
      .head          (head),
      .pop           (pop),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .ram_rd_data_a (ram_rd_data_a),
      .ram_rd_data_b (ram_rd_data_b),
      .rsp_chan      (rsp_chan)
   );

endmodule
